### rtl/core/mcs_pkg.sv
package mcs_pkg;

  // Field widths fixed by the command and phase formats.
  localparam int unsigned CmdW     = 2;
  localparam int unsigned SpeedW   = 8;
  localparam int unsigned PctW     = 7;
  localparam int unsigned LevelW   = 8;
  localparam int unsigned HoldW    = 10;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 10;

  // PWM counter top and the percent that maps to it.
  localparam int unsigned PwmTop  = 255;
  localparam int unsigned PctFull = 100;

  // A command produces at most three phases.
  localparam int unsigned MaxPhases = 3;
  localparam int unsigned CountW    = 2;

  typedef enum logic [CmdW-1:0] {
    CmdForward  = 2'd0,
    CmdBackward = 2'd1,
    CmdStop     = 2'd2,
    CmdInvert   = 2'd3
  } cmd_e;

  typedef enum logic [CfgAddrW-1:0] {
    RegBrakeMs     = 2'd0,
    RegKickMs      = 2'd1,
    RegMinStartPct = 2'd2,
    RegInvertGapMs = 2'd3
  } reg_idx_e;

  typedef logic [PctW-1:0]   pct_t;
  typedef logic [LevelW-1:0] level_t;
  typedef logic [HoldW-1:0]  hold_t;

  localparam hold_t BrakeMsReset     = 10'd50;
  localparam hold_t KickMsReset      = 10'd80;
  localparam pct_t  MinStartPctReset = 7'd15;
  localparam hold_t InvertGapMsReset = 10'd50;

  typedef struct packed {
    level_t fwd_level;
    level_t rev_level;
    logic   fwd_enable;
    logic   rev_enable;
    hold_t  hold_ms;
    logic   last;
  } phase_t;

  typedef struct packed {
    phase_t [MaxPhases-1:0] phases;
    logic   [CountW-1:0]    count;
  } plan_t;

  typedef struct packed {
    hold_t brake_ms;
    hold_t kick_ms;
    pct_t  min_start_pct;
    hold_t invert_gap_ms;
  } cfg_t;

  // Percent to PWM level, one entry per 7-bit percent value.
  localparam int unsigned LevelEntries = 2 ** PctW;
  localparam int unsigned LevelMax     = 2 ** LevelW - 1;

  typedef logic [LevelEntries-1:0][LevelW-1:0] level_tbl_t;

  function automatic level_tbl_t build_level_table();
    level_tbl_t  tbl;
    int unsigned lv;
    for (int unsigned p = 0; p < LevelEntries; p++) begin
      if (p == 0) begin
        lv = 0;
      end else if (p >= PctFull) begin
        lv = PwmTop;
      end else begin
        lv = (p * PwmTop) / PctFull;
      end
      if (lv > LevelMax) begin
        lv = LevelMax;
      end
      tbl[p] = lv[LevelW-1:0];
    end
    return tbl;
  endfunction

  localparam level_tbl_t LevelTable = build_level_table();

endpackage

### rtl/core/mcs_plan.sv
module mcs_plan (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mcs_pkg::cmd_e  cmd_i,
  input  logic [7:0]     speed_i,
  input  mcs_pkg::cfg_t  cfg_i,
  input  logic           load_i,
  output mcs_pkg::plan_t plan_o
);
  import mcs_pkg::*;

  pct_t   cur_speed_q, cur_speed_d;
  logic   dir_fwd_q, dir_fwd_d;
  logic   running_q, running_d;

  pct_t   spd_sat;
  pct_t   run_pct;
  logic   run_fwd;
  level_t run_lv;
  level_t kick_lv;
  logic   run_en;
  logic   brake_c;
  logic   kick_c;

  phase_t brake_ph, kick_ph, idle_ph, release_ph, run_ph;
  phase_t [MaxPhases-1:0] cand;
  logic   [MaxPhases-1:0] cand_en;
  logic   [CountW-1:0]    slot;

  assign spd_sat = (speed_i > SpeedW'(PctFull)) ? PctW'(PctFull) : speed_i[PctW-1:0];

  always_comb begin
    run_fwd = (cmd_i == CmdInvert) ? !dir_fwd_q : (cmd_i == CmdForward);
    run_pct = (cmd_i == CmdInvert) ? cur_speed_q : spd_sat;
  end

  assign run_lv  = LevelTable[run_pct];
  assign kick_lv = LevelTable[cfg_i.min_start_pct];
  assign run_en  = (run_lv != '0);

  // Forward/backward brake only if a running motor is reversed to nonzero speed.
  assign brake_c = (dir_fwd_q != run_fwd) && running_q && (spd_sat != '0);
  assign kick_c  = (spd_sat != '0) && (spd_sat < cfg_i.min_start_pct);

  always_comb begin
    brake_ph   = '{fwd_level: '0, rev_level: '0, fwd_enable: 1'b1, rev_enable: 1'b1,
                   hold_ms: cfg_i.brake_ms, last: 1'b0};
    idle_ph    = '{fwd_level: '0, rev_level: '0, fwd_enable: 1'b0, rev_enable: 1'b0,
                   hold_ms: cfg_i.invert_gap_ms, last: 1'b0};
    release_ph = '{fwd_level: '0, rev_level: '0, fwd_enable: 1'b0, rev_enable: 1'b0,
                   hold_ms: '0, last: 1'b1};
    kick_ph    = '{fwd_level: '0, rev_level: '0, fwd_enable: 1'b0, rev_enable: 1'b0,
                   hold_ms: cfg_i.kick_ms, last: 1'b0};
    run_ph     = '{fwd_level: '0, rev_level: '0, fwd_enable: 1'b0, rev_enable: 1'b0,
                   hold_ms: '0, last: 1'b1};
    if (run_fwd) begin
      kick_ph.fwd_level  = kick_lv;
      kick_ph.fwd_enable = 1'b1;
      run_ph.fwd_level   = run_lv;
      run_ph.fwd_enable  = run_en;
    end else begin
      kick_ph.rev_level  = kick_lv;
      kick_ph.rev_enable = 1'b1;
      run_ph.rev_level   = run_lv;
      run_ph.rev_enable  = run_en;
    end
  end

  // Candidate phases in emission order, then packed to the front.
  always_comb begin
    cand        = '0;
    cand_en     = '0;
    cur_speed_d = cur_speed_q;
    dir_fwd_d   = dir_fwd_q;
    running_d   = running_q;
    unique case (cmd_i)
      CmdForward, CmdBackward: begin
        cand[0]     = brake_ph;
        cand[1]     = kick_ph;
        cand[2]     = run_ph;
        cand_en     = {1'b1, kick_c, brake_c};
        cur_speed_d = spd_sat;
        dir_fwd_d   = run_fwd;
        running_d   = run_en;
      end
      CmdStop: begin
        cand[0]     = brake_ph;
        cand[1]     = release_ph;
        cand_en     = 3'b011;
        cur_speed_d = '0;
        running_d   = 1'b0;
      end
      CmdInvert: begin
        cand[0] = brake_ph;
        cand[1] = idle_ph;
        cand[2] = run_ph;
        if (cur_speed_q != '0) begin
          cand_en   = 3'b111;
          dir_fwd_d = run_fwd;
          running_d = run_en;
        end
      end
      default: begin
        cand_en = '0;
      end
    endcase
  end

  always_comb begin
    plan_o = '0;
    slot   = '0;
    for (int i = 0; i < MaxPhases; i++) begin
      if (cand_en[i]) begin
        plan_o.phases[slot] = cand[i];
        slot                = slot + 1'b1;
      end
    end
    plan_o.count = slot;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_speed_q <= '0;
      dir_fwd_q   <= 1'b1;
      running_q   <= 1'b0;
    end else if (load_i) begin
      cur_speed_q <= cur_speed_d;
      dir_fwd_q   <= dir_fwd_d;
      running_q   <= running_d;
    end
  end

endmodule

### rtl/core/mcs_burst.sv
module mcs_burst (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  mcs_pkg::plan_t  plan_i,
  input  logic            out_stall_i,
  output logic            free_o,
  output logic            out_valid_o,
  output mcs_pkg::phase_t phase_o
);
  import mcs_pkg::*;

  phase_t [MaxPhases-1:0] phases_q, phases_d;
  logic   [CountW-1:0]    n_q, n_d;
  logic                   pop;

  assign out_valid_o = (n_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign free_o      = (n_q == '0) || ((n_q == CountW'(1)) && pop);
  assign phase_o     = phases_q[0];

  always_comb begin
    phases_d = phases_q;
    n_d      = n_q;
    if (load_i) begin
      phases_d = plan_i.phases;
      n_d      = plan_i.count;
    end else if (pop) begin
      for (int i = 0; i < MaxPhases - 1; i++) begin
        phases_d[i] = phases_q[i+1];
      end
      n_d = n_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    phases_q <= phases_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= '0;
    end else begin
      n_q <= n_d;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= CountW'(MaxPhases))
    else $error("phase count above the burst depth");

  a_last_on_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (n_q == CountW'(1))) |-> phase_o.last)
    else $error("final phase of a command without last");

  a_no_early_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (n_q > CountW'(1))) |-> !phase_o.last)
    else $error("last set before the final phase");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_i && (plan_i.count != '0)) |=> out_valid_o)
    else $error("loaded phases not presented");

  a_load_only_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("load while earlier phases remain");

endmodule

### rtl/core/h_bridge_motor_command_sequencer.sv
// H-bridge DC motor command sequencer.
//
// A request on the input channel (cmd_i, speed_i with in_valid_i / in_stall_o)
// is a motor command: forward, backward, stop or invert. The block turns it
// into zero to three drive phases on the output channel (out_valid_o /
// out_stall_i), each with the PWM levels and enables of both bridge halves,
// a hold time in milliseconds and a flag marking the final phase of the
// command. An invert while the stored speed is zero yields no phase at all.
//
// The request is captured in an input register. While it is held there, the
// phase list is worked out and, once the phase buffer is free, loaded into
// the three-entry phase buffer, which offers the first phase in the cycle
// after the load. The phase buffer then drains one phase per cycle while
// out_stall_i is low, and the next request waits in the input register
// while the buffer drains; it is loaded in the cycle in which the final
// phase of its predecessor is taken. A stalled receiver holds the offered
// phase steady; the input register fills and in_stall_o rises behind it.
//
// Reset clears the speed, sets the direction to forward, marks the motor
// stopped and restores the timing registers to their defaults. The user must
// write the timing registers via cfg_we_i only when idle; it is not enforced.
module h_bridge_motor_command_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [9:0]  cfg_wdata_i,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  speed_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  fwd_level_o,
  output logic [7:0]  rev_level_o,
  output logic        fwd_enable_o,
  output logic        rev_enable_o,
  output logic [9:0]  hold_ms_o,
  output logic        last_o
);
  import mcs_pkg::*;

  // Configuration registers.
  cfg_t   cfg_q;

  // Input register holding one request until the phase buffer takes it.
  logic   in_valid_q;
  cmd_e   cmd_q;
  logic [SpeedW-1:0] speed_q;

  logic   load;
  logic   burst_free;
  logic   in_accept;
  plan_t  plan;
  phase_t phase;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.brake_ms      <= BrakeMsReset;
      cfg_q.kick_ms       <= KickMsReset;
      cfg_q.min_start_pct <= MinStartPctReset;
      cfg_q.invert_gap_ms <= InvertGapMsReset;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_addr_i))
        RegBrakeMs:     cfg_q.brake_ms      <= cfg_wdata_i[HoldW-1:0];
        RegKickMs:      cfg_q.kick_ms       <= cfg_wdata_i[HoldW-1:0];
        RegMinStartPct: cfg_q.min_start_pct <= cfg_wdata_i[PctW-1:0];
        RegInvertGapMs: cfg_q.invert_gap_ms <= cfg_wdata_i[HoldW-1:0];
        default: ;
      endcase
    end
  end

  // The held request moves on as soon as the phase buffer is free, which
  // includes the cycle in which its final phase is taken.
  assign load       = in_valid_q && burst_free;
  assign in_stall_o = in_valid_q && !load;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (load) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q   <= cmd_e'(cmd_i);
      speed_q <= speed_i;
    end
  end

  // Phase list and motor state.
  mcs_plan u_plan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_q),
    .speed_i (speed_q),
    .cfg_i   (cfg_q),
    .load_i  (load),
    .plan_o  (plan)
  );

  // Phase buffer feeding the output channel.
  mcs_burst u_burst (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .plan_i      (plan),
    .out_stall_i (out_stall_i),
    .free_o      (burst_free),
    .out_valid_o (out_valid_o),
    .phase_o     (phase)
  );

  assign fwd_level_o  = phase.fwd_level;
  assign rev_level_o  = phase.rev_level;
  assign fwd_enable_o = phase.fwd_enable;
  assign rev_enable_o = phase.rev_enable;
  assign hold_ms_o    = phase.hold_ms;
  assign last_o       = phase.last;

endmodule
